FILE: src/assert_macros.svh
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define SPSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SPSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/spsl_pkg.sv
// types and constants for the servo slew limiter
`default_nettype none

package spsl_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int NUM_SERVOS = 8;
    localparam int SLOT_W     = 3;
    localparam int DUTY_W     = 14;
    localparam int STEP_W     = 10;
    localparam int ANGLE_W    = 13;
    localparam int CFG_IDX_W  = 2;

    // angle*25/72 as a multiply by a scaled reciprocal, exact for 12-bit angles
    localparam int RAW_W       = 11;
    localparam int ANGLE_MAG_W = ANGLE_W - 1;
    localparam int MULT_W      = 19;
    localparam int PROD_W      = ANGLE_MAG_W + MULT_W;
    localparam int ANGLE_SHIFT = 20;
    localparam logic [MULT_W-1:0] ANGLE_MULT = 19'd364089;

    localparam logic [DUTY_W-1:0] DUTY_BASE      = 14'd250;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 14'd250;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 14'd1250;
    localparam logic [STEP_W-1:0] NEAR_THR_RST   = 10'd10;
    localparam logic [STEP_W-1:0] COARSE_STEP_RST = 10'd10;

    typedef logic [DUTY_W-1:0] duty_t;
    typedef duty_t duty_arr_t [NUM_SLOTS];

    // reset value of each current duty
    localparam duty_t CUR_INIT [NUM_SLOTS] = '{
        14'd500, 14'd0, 14'd500, 14'd750, 14'd750, 14'd750, 14'd500, 14'd500
    };

    typedef enum logic {
        KIND_SET  = 1'b0,
        KIND_TICK = 1'b1
    } spsl_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_MIN    = 2'd0,
        REG_DUTY_MAX    = 2'd1,
        REG_NEAR_THR    = 2'd2,
        REG_COARSE_STEP = 2'd3
    } spsl_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [STEP_W-1:0] near_threshold;
        logic [STEP_W-1:0] coarse_step;
    } spsl_cfg_t;

endpackage

`default_nettype wire

FILE: src/servo_pwm_slew_limiter_core.sv
// servo duty slew limiter: top level
// Usage:
//   Input channel (s_*): one transaction per item. s_kind selects a set item,
//   which converts s_angle (signed Q8.4 degrees) into a clamped target duty
//   for servo s_servo_index (negative angles are ignored), or a tick item,
//   which steps all eight current duties toward their targets.
//   Result channel (m_*): exactly one transaction per item, carrying all
//   eight current duties and m_all_settled.
//   Config channel (cfg_*): always ready; index 0 duty_min, 1 duty_max,
//   2 near_threshold, 3 coarse_step. Write only while the block is idle.
// Timing:
//   An item is held in the input register, then the state and the
//   result register update together once the result register frees up.
//   One item per cycle is sustained while m_ready stays high; the angle
//   multiplier sits ahead of the input register, the slew and clamp logic
//   between it and the result register.
// Reset (aresetn low, synchronous): targets go to 250, duties to their
//   start values, registers to their defaults, both pipeline stages empty.
// Stall: a held result keeps m_* steady; one more item is still taken into
//   the input register, after which s_ready drops until m_ready returns.
`default_nettype none

module servo_pwm_slew_limiter_core
    import spsl_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    // config write channel
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [DUTY_W-1:0]      cfg_data,
    // input channel
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_kind,
    input  wire [SLOT_W-1:0]      s_servo_index,
    input  wire signed [ANGLE_W-1:0] s_angle,
    // result channel
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_all_settled,
    output logic [DUTY_W-1:0]     m_duty_0,
    output logic [DUTY_W-1:0]     m_duty_1,
    output logic [DUTY_W-1:0]     m_duty_2,
    output logic [DUTY_W-1:0]     m_duty_3,
    output logic [DUTY_W-1:0]     m_duty_4,
    output logic [DUTY_W-1:0]     m_duty_5,
    output logic [DUTY_W-1:0]     m_duty_6,
    output logic [DUTY_W-1:0]     m_duty_7
);

    spsl_cfg_t   cfg_reg;
    logic        in_valid_reg;
    spsl_kind_t  in_kind_reg;
    logic [SLOT_W-1:0] in_idx_reg;
    logic        in_neg_reg;
    logic [RAW_W-1:0]  in_raw_reg;
    duty_arr_t   target_reg;
    duty_arr_t   current_reg;
    logic        out_valid_reg;
    logic        settled_reg;
    duty_arr_t   duty_reg;

    logic [PROD_W-1:0] angle_prod;
    logic        advance;
    duty_t       cand;
    duty_t       clamped;
    duty_arr_t   slewed;
    duty_arr_t   target_next;
    duty_arr_t   current_next;
    logic        settled_next;

    // config register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_min       <= DUTY_MIN_RST;
            cfg_reg.duty_max       <= DUTY_MAX_RST;
            cfg_reg.near_threshold <= NEAR_THR_RST;
            cfg_reg.coarse_step    <= COARSE_STEP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (spsl_reg_t'(cfg_index))
                REG_DUTY_MIN:    cfg_reg.duty_min       <= cfg_data;
                REG_DUTY_MAX:    cfg_reg.duty_max       <= cfg_data;
                REG_NEAR_THR:    cfg_reg.near_threshold <= cfg_data[STEP_W-1:0];
                REG_COARSE_STEP: cfg_reg.coarse_step    <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the input stage moves on when the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // angle scaling ahead of the input register
    assign angle_prod = PROD_W'(s_angle[ANGLE_MAG_W-1:0]) * PROD_W'(ANGLE_MULT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= spsl_kind_t'(s_kind);
            in_idx_reg  <= s_servo_index;
            in_neg_reg  <= s_angle[ANGLE_W-1];
            in_raw_reg  <= angle_prod[ANGLE_SHIFT +: RAW_W];
        end
    end

    // target clamp: max first, then min
    always_comb begin
        cand    = {{(DUTY_W-RAW_W){1'b0}}, in_raw_reg} + DUTY_BASE;
        clamped = (cand > cfg_reg.duty_max) ? cfg_reg.duty_max : cand;
        if (clamped < cfg_reg.duty_min) begin
            clamped = cfg_reg.duty_min;
        end
    end

    // per-servo slew units
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_chan
        spsl_channel u_chan (
            .cur      (current_reg[k]),
            .tgt      (target_reg[k]),
            .cfg      (cfg_reg),
            .cur_next (slewed[k])
        );
    end

    // next state and settled flag
    always_comb begin
        target_next  = target_reg;
        current_next = current_reg;
        settled_next = 1'b1;
        if (advance) begin
            case (in_kind_reg)
                KIND_SET: begin
                    if (!in_neg_reg && (int'(in_idx_reg) < NUM_SERVOS)) begin
                        target_next[in_idx_reg] = clamped;
                    end
                end
                KIND_TICK: begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (k < NUM_SERVOS) begin
                            current_next[k] = slewed[k];
                        end
                    end
                end
                default: ;
            endcase
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if ((k < NUM_SERVOS) && (current_next[k] != target_next[k])) begin
                settled_next = 1'b0;
            end
        end
    end

    // servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                target_reg[k]  <= DUTY_BASE;
                current_reg[k] <= CUR_INIT[k];
            end
        end else begin
            target_reg  <= target_next;
            current_reg <= current_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            settled_reg <= settled_next;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                duty_reg[k] <= (k < NUM_SERVOS) ? current_next[k] : '0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_all_settled = settled_reg;
    assign m_duty_0      = duty_reg[0];
    assign m_duty_1      = duty_reg[1];
    assign m_duty_2      = duty_reg[2];
    assign m_duty_3      = duty_reg[3];
    assign m_duty_4      = duty_reg[4];
    assign m_duty_5      = duty_reg[5];
    assign m_duty_6      = duty_reg[6];
    assign m_duty_7      = duty_reg[7];

endmodule

`default_nettype wire

FILE: src/spsl_channel.sv
// one servo channel: a single slew step of the current duty toward its target
`default_nettype none

module spsl_channel
    import spsl_pkg::*;
(
    input  wire duty_t     cur,
    input  wire duty_t     tgt,
    input  wire spsl_cfg_t cfg,
    output duty_t          cur_next
);

    duty_t gap;
    duty_t coarse;
    duty_t mag;
    logic  above;

    // distance to target and step size
    always_comb begin
        above  = cur > tgt;
        gap    = above ? (cur - tgt) : (tgt - cur);
        coarse = {{(DUTY_W-STEP_W){1'b0}}, cfg.coarse_step};
        if (gap > {{(DUTY_W-STEP_W){1'b0}}, cfg.near_threshold}) begin
            mag = (coarse > gap) ? gap : coarse;
        end else if (gap == '0) begin
            mag = '0;
        end else begin
            mag = duty_t'(1);
        end
    end

    // move toward target, never past it
    assign cur_next = above ? (cur - mag) : (cur + mag);

endmodule

`default_nettype wire

FILE: src/spsl_checker.sv
// port-level checks for the servo slew limiter, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module spsl_checker
    import spsl_pkg::*;
(
    input wire              aclk,
    input wire              aresetn,
    input wire              s_ready,
    input wire              m_valid,
    input wire              m_ready,
    input wire              m_all_settled,
    input wire [DUTY_W-1:0] m_duty_0,
    input wire [DUTY_W-1:0] m_duty_1,
    input wire [DUTY_W-1:0] m_duty_2,
    input wire [DUTY_W-1:0] m_duty_3,
    input wire [DUTY_W-1:0] m_duty_4,
    input wire [DUTY_W-1:0] m_duty_5,
    input wire [DUTY_W-1:0] m_duty_6,
    input wire [DUTY_W-1:0] m_duty_7
);

    // a stalled result transaction stays offered
    `SPSL_ASSERT(a_hold_valid, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // a stalled result transaction keeps its payload
    `SPSL_ASSERT(a_hold_data, m_valid && !m_ready |=> $stable(m_all_settled) && $stable(m_duty_0) && $stable(m_duty_1) && $stable(m_duty_2) && $stable(m_duty_3) && $stable(m_duty_4) && $stable(m_duty_5) && $stable(m_duty_6) && $stable(m_duty_7), "result changed while stalled")

    // input back-pressure only comes from a stalled result
    `SPSL_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready, "input stalled without output stall")

    // reset empties both pipeline stages
    `SPSL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && s_ready, "pipeline not empty after reset")

endmodule

bind servo_pwm_slew_limiter_core spsl_checker u_spsl_checker (.*);

`default_nettype wire

FILE: dv/spsl_duty_checker.sv
// result checker for the servo slew limiter: predicts every result and compares it
`timescale 1ns / 100ps

module spsl_duty_checker
    import spsl_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_valid,
    input  wire                      cfg_ready,
    input  wire [CFG_IDX_W-1:0]      cfg_index,
    input  wire [DUTY_W-1:0]         cfg_data,
    input  wire                      s_valid,
    input  wire                      s_ready,
    input  wire                      s_kind,
    input  wire [SLOT_W-1:0]         s_servo_index,
    input  wire signed [ANGLE_W-1:0] s_angle,
    input  wire                      m_valid,
    input  wire                      m_ready,
    input  wire                      m_all_settled,
    input  wire [DUTY_W-1:0]         m_duty_0,
    input  wire [DUTY_W-1:0]         m_duty_1,
    input  wire [DUTY_W-1:0]         m_duty_2,
    input  wire [DUTY_W-1:0]         m_duty_3,
    input  wire [DUTY_W-1:0]         m_duty_4,
    input  wire [DUTY_W-1:0]         m_duty_5,
    input  wire [DUTY_W-1:0]         m_duty_6,
    input  wire [DUTY_W-1:0]         m_duty_7,
    output int                       fail_count,
    output int                       pending_count
);

    // angle scaling: degrees*10000/1800 on a Q8.4 angle is raw*50/144
    localparam int ANGLE_NUM = 50;
    localparam int ANGLE_DEN = 144;

    typedef struct packed {
        logic                             settled;
        logic [NUM_SLOTS-1:0][DUTY_W-1:0] duty;
    } duty_report_t;

    duty_arr_t    target_m;
    duty_arr_t    current_m;
    spsl_cfg_t    cfg_m;
    duty_report_t pending_reports [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // angle magnitude to clamped target duty, max limit first, min wins
    function automatic duty_t angle_duty(logic [ANGLE_W-2:0] mag);
        int raw;
        raw = int'(mag) * ANGLE_NUM / ANGLE_DEN + int'(DUTY_BASE);
        if (raw > int'(cfg_m.duty_max)) raw = int'(cfg_m.duty_max);
        if (raw < int'(cfg_m.duty_min)) raw = int'(cfg_m.duty_min);
        return duty_t'(raw);
    endfunction

    // one slew step of a duty toward its target, never overshooting
    function automatic duty_t slew_step(duty_t cur, duty_t tgt);
        int gap;
        int step;
        gap = (cur > tgt) ? int'(cur) - int'(tgt) : int'(tgt) - int'(cur);
        if (gap == 0) return cur;
        if (gap > int'(cfg_m.near_threshold)) begin
            step = int'(cfg_m.coarse_step);
            if (step > gap) step = gap;
        end else begin
            step = 1;
        end
        return (cur > tgt) ? duty_t'(int'(cur) - step) : duty_t'(int'(cur) + step);
    endfunction

    // apply one item to the servo state and return the result it causes
    function automatic duty_report_t advance_servos(logic kind, logic [SLOT_W-1:0] idx,
                                                    logic [ANGLE_W-1:0] ang);
        duty_report_t rep;
        if (kind == KIND_SET) begin
            if (!ang[ANGLE_W-1] && int'(idx) < NUM_SERVOS)
                target_m[idx] = angle_duty(ang[ANGLE_W-2:0]);
        end else begin
            for (int k = 0; k < NUM_SERVOS; k++)
                current_m[k] = slew_step(current_m[k], target_m[k]);
        end
        rep.settled = 1'b1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (k < NUM_SERVOS) begin
                rep.duty[k] = current_m[k];
                if (current_m[k] != target_m[k]) rep.settled = 1'b0;
            end else begin
                rep.duty[k] = '0;
            end
        end
        return rep;
    endfunction

    // watch all three channels at the clock edge
    always @(posedge aclk) begin : monitor
        duty_report_t seen;
        duty_report_t want;
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                target_m[k]  = DUTY_BASE;
                current_m[k] = CUR_INIT[k];
            end
            cfg_m.duty_min       = DUTY_MIN_RST;
            cfg_m.duty_max       = DUTY_MAX_RST;
            cfg_m.near_threshold = NEAR_THR_RST;
            cfg_m.coarse_step    = COARSE_STEP_RST;
            pending_reports.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DUTY_MIN:    cfg_m.duty_min       = cfg_data;
                    REG_DUTY_MAX:    cfg_m.duty_max       = cfg_data;
                    REG_NEAR_THR:    cfg_m.near_threshold = cfg_data[STEP_W-1:0];
                    REG_COARSE_STEP: cfg_m.coarse_step    = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                seen.settled = m_all_settled;
                seen.duty    = {m_duty_7, m_duty_6, m_duty_5, m_duty_4,
                                m_duty_3, m_duty_2, m_duty_1, m_duty_0};
                if (pending_reports.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (seen.settled !== want.settled) begin
                        $error("all_settled: expected %0d, actual %0d",
                               want.settled, seen.settled);
                        fail_count++;
                    end
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (seen.duty[k] !== want.duty[k]) begin
                            $error("duty_%0d: expected %0d, actual %0d",
                                   k, want.duty[k], seen.duty[k]);
                            fail_count++;
                        end
                    end
                end
            end
            // input transaction
            if (s_valid && s_ready)
                pending_reports.push_back(advance_servos(s_kind, s_servo_index, s_angle));
        end
        pending_count <= pending_reports.size();
    end

endmodule

FILE: dv/tb_servo_pwm_slew_limiter_core.sv
// testbench top for the servo slew limiter: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_servo_pwm_slew_limiter_core;
    import spsl_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 120;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int MAX_GAP         = 30;
    localparam int TAIL_CYCLES     = 6;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [DUTY_W-1:0]         cfg_data      = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_kind        = 1'b0;
    logic [SLOT_W-1:0]         s_servo_index = '0;
    logic signed [ANGLE_W-1:0] s_angle       = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_all_settled;
    logic [DUTY_W-1:0]         m_duty_0, m_duty_1, m_duty_2, m_duty_3;
    logic [DUTY_W-1:0]         m_duty_4, m_duty_5, m_duty_6, m_duty_7;

    int fail_count;
    int pending_count;
    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int hold_asks       = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int cycle_count     = 0;

    servo_pwm_slew_limiter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_servo_index (s_servo_index),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_all_settled (m_all_settled),
        .m_duty_0      (m_duty_0),
        .m_duty_1      (m_duty_1),
        .m_duty_2      (m_duty_2),
        .m_duty_3      (m_duty_3),
        .m_duty_4      (m_duty_4),
        .m_duty_5      (m_duty_5),
        .m_duty_6      (m_duty_6),
        .m_duty_7      (m_duty_7)
    );

    spsl_duty_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_servo_index (s_servo_index),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_all_settled (m_all_settled),
        .m_duty_0      (m_duty_0),
        .m_duty_1      (m_duty_1),
        .m_duty_2      (m_duty_2),
        .m_duty_3      (m_duty_3),
        .m_duty_4      (m_duty_4),
        .m_duty_5      (m_duty_5),
        .m_duty_6      (m_duty_6),
        .m_duty_7      (m_duty_7),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // offer one item, idling first at the phase's rate, and wait for its transaction
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] idx,
                             input logic [ANGLE_W-1:0] ang);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_servo_index <= idx;
        s_angle       <= ang;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input spsl_reg_t idx, input logic [DUTY_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input int dmin, input int dmax, input int thr, input int step);
        write_reg(REG_DUTY_MIN, DUTY_W'(dmin));
        write_reg(REG_DUTY_MAX, DUTY_W'(dmax));
        write_reg(REG_NEAR_THR, DUTY_W'(thr));
        write_reg(REG_COARSE_STEP, DUTY_W'(step));
    endtask

    // one random phase: bursts of set items followed by runs of ticks
    task automatic run_phase(input int dmin, input int dmax, input int thr, input int step,
                             input int send_pct, input int stall_pct, input bit hold);
        int          sent;
        int          burst;
        logic [31:0] r;
        logic [31:0] a;
        drain_results();
        write_all_regs(dmin, dmax, thr, step);
        send_idle_pct   = send_pct;
        ready_stall_pct = stall_pct;
        if (hold) hold_asks++;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(3);
            repeat (burst) begin
                r = $urandom;
                a = $urandom;
                // mostly valid angles, some negative or fully random
                if (r[7:4] < 4'd13)
                    send_item(KIND_SET, r[2:0], {1'b0, a[ANGLE_W-2:0]});
                else
                    send_item(KIND_SET, r[2:0], a[ANGLE_W-1:0]);
                sent++;
            end
            burst = $urandom_range(40);
            repeat (burst) begin
                r = $urandom;
                send_item(KIND_TICK, r[2:0], r[20:8]);
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed: conversion extremes, ignored angles, ticks at reset settings
        send_item(KIND_TICK, 3'd0, 13'd0);
        send_item(KIND_SET, 3'd0, 13'd0);
        send_item(KIND_SET, 3'd7, 13'd4095);
        send_item(KIND_SET, 3'd1, -13'sd4096);
        send_item(KIND_SET, 3'd2, -13'sd1);
        send_item(KIND_SET, 3'd3, 13'd1440);
        send_item(KIND_SET, 3'd4, 13'd1);
        send_item(KIND_SET, 3'd5, 13'd2880);
        send_item(KIND_SET, 3'd6, 13'd144);
        repeat (6) send_item(KIND_TICK, 3'd7, 13'h1FFF);

        // minimum above maximum: the minimum wins
        drain_results();
        write_reg(REG_DUTY_MIN, 14'd800);
        write_reg(REG_DUTY_MAX, 14'd600);
        send_item(KIND_SET, 3'd0, 13'd4095);
        send_item(KIND_SET, 3'd1, 13'd0);
        repeat (2) send_item(KIND_TICK, 3'd0, 13'd0);

        // zero coarse step with zero threshold: nothing moves
        drain_results();
        write_reg(REG_NEAR_THR, 14'd0);
        write_reg(REG_COARSE_STEP, 14'd0);
        repeat (2) send_item(KIND_TICK, 3'd0, 13'd0);

        // random phases over several settings and idling modes
        run_phase(250, 1250, 10, 10, 0, 0, 1'b1);
        run_phase(0, 9999, 0, 1023, 59, 0, 1'b0);
        run_phase(0, 9999, 1023, 0, 0, 59, 1'b0);
        run_phase(9999, 0, 1023, 1, 25, 25, 1'b0);
        run_phase($urandom_range(1500), $urandom_range(9999), $urandom_range(1023),
                  $urandom_range(1023, 1), 0, 0, 1'b1);
        run_phase(0, 9999, 1023, 1023, 25, 25, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
